// ===== rtl/core/hipt_pkg.sv =====
// shared types and constants of the hashed index probe table
`default_nettype none

package hipt_pkg;

   localparam int KEY_WIDTH = 64;
   localparam int MIX_SHIFT = 33;
   localparam logic [63:0] MIX_C1 = 64'hff51afd7ed558ccd;
   localparam logic [63:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;
   localparam int QUEUE_DEPTH = 2;

   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_INSERT = 1'b1;

   localparam logic [1:0] KIND_FILL   = 2'd0;
   localparam logic [1:0] KIND_UPDATE = 2'd1;
   localparam logic [1:0] KIND_EVICT  = 2'd2;

   typedef enum logic [1:0] {
      F_IDLE,
      F_MUL,
      F_MIX,
      F_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      B_CLEAR,
      B_IDLE,
      B_CHECK
   } back_state_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

`default_nettype wire

// ===== rtl/core/hipt_ram.sv =====
// generic single-port ram with registered read
`default_nettype none

module hipt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== rtl/core/hipt_queue.sv =====
// small fifo between the hashing front and the probing back
`default_nettype none

module hipt_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire logic [WIDTH-1:0]        push_data,
   input  wire logic                    pop,
   output logic      [WIDTH-1:0]        head_data,
   output hipt_pkg::queue_status_type   status
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   always_comb begin
      do_push   = push && !status.full;
      do_pop    = pop && !status.empty;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data = entry_ff[rd_ptr_ff];
   // empty is the upper bit of the status, full the lower
   assign status    = {(count_ff == '0), (count_ff == NW'(DEPTH))};

endmodule

`default_nettype wire

// ===== rtl/core/hipt_front.sv =====
// front end: takes transactions and computes the home slot by the murmur finaliser
`default_nettype none

module hipt_front #(
   parameter int TABLE_DEPTH = 1024,
   parameter int INDEX_WIDTH = 24
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic                            hold,
   input  wire logic                            req_operation,
   input  wire logic [hipt_pkg::KEY_WIDTH-1:0]  req_key,
   input  wire logic [INDEX_WIDTH-1:0]          req_index_in,
   input  wire logic                            queue_full,
   output logic                                 busy,
   output logic                                 push,
   output logic                                 push_operation,
   output logic      [hipt_pkg::KEY_WIDTH-1:0]  push_key,
   output logic      [INDEX_WIDTH-1:0]          push_index,
   output logic      [$clog2(TABLE_DEPTH)-1:0]  push_home
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int KW = hipt_pkg::KEY_WIDTH;

   hipt_pkg::front_state_type state_ff, state_in;

   logic                   round_ff, round_in;
   logic                   op_ff;
   logic [KW-1:0]          key_ff;
   logic [INDEX_WIDTH-1:0] idx_ff;
   logic [KW-1:0]          mix_ff, mix_in;
   logic [63:0]            p_ll_ff, p_ll_in;
   logic [31:0]            p_hl_ff, p_hl_in;
   logic [31:0]            p_lh_ff, p_lh_in;
   logic [63:0]            coef;
   logic [63:0]            sum;
   logic                   accept;

   assign accept = start && !busy;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hipt_pkg::F_IDLE: begin
            if (accept) begin
               state_in = hipt_pkg::F_MUL;
            end
         end
         hipt_pkg::F_MUL: begin
            state_in = hipt_pkg::F_MIX;
         end
         hipt_pkg::F_MIX: begin
            state_in = round_ff ? hipt_pkg::F_PUSH : hipt_pkg::F_MUL;
         end
         hipt_pkg::F_PUSH: begin
            if (!queue_full) begin
               state_in = hipt_pkg::F_IDLE;
            end
         end
         default: begin
            state_in = hipt_pkg::F_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      busy = hold;
      push = 1'b0;
      unique case (state_ff)
         hipt_pkg::F_IDLE: begin
            busy = hold;
         end
         hipt_pkg::F_MUL, hipt_pkg::F_MIX: begin
            busy = 1'b1;
         end
         hipt_pkg::F_PUSH: begin
            busy = 1'b1;
            push = !queue_full;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   // low 64 bits of the product from three partial products
   always_comb begin
      coef     = round_ff ? hipt_pkg::MIX_C2 : hipt_pkg::MIX_C1;
      p_ll_in  = {32'b0, mix_ff[31:0]} * {32'b0, coef[31:0]};
      p_hl_in  = mix_ff[63:32] * coef[31:0];
      p_lh_in  = mix_ff[31:0] * coef[63:32];
      sum      = p_ll_ff + {p_hl_ff + p_lh_ff, 32'b0};
      mix_in   = mix_ff;
      round_in = round_ff;
      if (accept) begin
         mix_in   = req_key ^ (req_key >> hipt_pkg::MIX_SHIFT);
         round_in = 1'b0;
      end else if (state_ff == hipt_pkg::F_MIX) begin
         mix_in   = sum ^ (sum >> hipt_pkg::MIX_SHIFT);
         round_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hipt_pkg::F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_operation;
         key_ff <= req_key;
         idx_ff <= req_index_in;
      end
      round_ff <= round_in;
      mix_ff   <= mix_in;
      p_ll_ff  <= p_ll_in;
      p_hl_ff  <= p_hl_in;
      p_lh_ff  <= p_lh_in;
   end

   assign push_operation = op_ff;
   assign push_key       = key_ff;
   assign push_index     = idx_ff;
   assign push_home      = mix_ff[AW-1:0];

endmodule

`default_nettype wire

// ===== rtl/core/hipt_back.sv =====
// back end: clears the table, probes slots linearly and writes inserts
`default_nettype none

module hipt_back #(
   parameter int TABLE_DEPTH = 1024,
   parameter int PROBE_LIMIT = 4,
   parameter int INDEX_WIDTH = 24
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire hipt_pkg::queue_status_type    queue_status,
   input  wire logic [hipt_pkg::KEY_WIDTH+INDEX_WIDTH+$clog2(TABLE_DEPTH):0] head_data,
   output logic                               pop,
   output logic                               clearing,
   output logic                               rsp_strobe,
   output logic                               rsp_hit,
   output logic      [INDEX_WIDTH-1:0]        rsp_index_out,
   output logic      [1:0]                    rsp_insert_kind
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int KW = hipt_pkg::KEY_WIDTH;
   localparam int CW = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;
   localparam int RW = 1 + KW + INDEX_WIDTH;
   localparam int EW = 1 + KW + INDEX_WIDTH + AW;

   hipt_pkg::back_state_type state_ff, state_in;

   logic [AW-1:0]          clr_ff, clr_in;
   logic                   op_ff;
   logic [KW-1:0]          key_ff;
   logic [INDEX_WIDTH-1:0] idx_ff;
   logic [AW-1:0]          home_ff;
   logic [AW-1:0]          slot_ff;
   logic [CW-1:0]          cnt_ff;

   logic                   head_op;
   logic [KW-1:0]          head_key;
   logic [INDEX_WIDTH-1:0] head_idx;
   logic [AW-1:0]          head_home;

   logic                   ram_we;
   logic [AW-1:0]          ram_addr;
   logic [RW-1:0]          ram_wdata;
   logic [RW-1:0]          ram_rdata;
   logic                   rd_valid;
   logic [KW-1:0]          rd_key;
   logic [INDEX_WIDTH-1:0] rd_index;

   logic                   rd_match, qualify, last, done;
   logic [AW-1:0]          target;
   logic [1:0]             kind;
   logic                   rsp_load;

   logic                   strobe_ff;
   logic                   hit_ff;
   logic [INDEX_WIDTH-1:0] index_ff;
   logic [1:0]             kind_ff;

   assign head_op   = head_data[EW-1];
   assign head_key  = head_data[EW-2 -: KW];
   assign head_idx  = head_data[AW +: INDEX_WIDTH];
   assign head_home = head_data[AW-1:0];

   assign rd_valid = ram_rdata[RW-1];
   assign rd_key   = ram_rdata[INDEX_WIDTH +: KW];
   assign rd_index = ram_rdata[INDEX_WIDTH-1:0];

   // probe decision; lookups and inserts both stop on an empty or matching slot
   always_comb begin
      rd_match = rd_valid && (rd_key == key_ff);
      qualify  = !rd_valid || rd_match;
      last     = (cnt_ff == CW'(PROBE_LIMIT - 1));
      done     = qualify || last;
      target   = qualify ? slot_ff : home_ff;
      if (qualify) begin
         kind = rd_valid ? hipt_pkg::KIND_UPDATE : hipt_pkg::KIND_FILL;
      end else begin
         kind = hipt_pkg::KIND_EVICT;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hipt_pkg::B_CLEAR: begin
            if (clr_ff == AW'(TABLE_DEPTH - 1)) begin
               state_in = hipt_pkg::B_IDLE;
            end
         end
         hipt_pkg::B_IDLE: begin
            if (!queue_status.empty) begin
               state_in = hipt_pkg::B_CHECK;
            end
         end
         hipt_pkg::B_CHECK: begin
            if (done) begin
               state_in = hipt_pkg::B_IDLE;
            end
         end
         default: begin
            state_in = hipt_pkg::B_CLEAR;
         end
      endcase
   end

   // outputs and ram port
   always_comb begin
      pop       = 1'b0;
      clearing  = 1'b0;
      rsp_load  = 1'b0;
      ram_we    = 1'b0;
      ram_addr  = slot_ff + 1'b1;
      ram_wdata = {1'b1, key_ff, idx_ff};
      unique case (state_ff)
         hipt_pkg::B_CLEAR: begin
            clearing  = 1'b1;
            ram_we    = 1'b1;
            ram_addr  = clr_ff;
            ram_wdata = '0;
         end
         hipt_pkg::B_IDLE: begin
            pop      = !queue_status.empty;
            ram_addr = head_home;
         end
         hipt_pkg::B_CHECK: begin
            rsp_load = done;
            // on the last probe of an insert the write replaces the next read
            if (done && (op_ff == hipt_pkg::OP_INSERT)) begin
               ram_we   = 1'b1;
               ram_addr = target;
            end
         end
         default: begin
            clearing = 1'b1;
         end
      endcase
   end

   assign clr_in = clr_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= hipt_pkg::B_CLEAR;
         clr_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= rsp_load;
         if (state_ff == hipt_pkg::B_CLEAR) begin
            clr_ff <= clr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         op_ff   <= head_op;
         key_ff  <= head_key;
         idx_ff  <= head_idx;
         home_ff <= head_home;
         slot_ff <= head_home;
         cnt_ff  <= '0;
      end else if ((state_ff == hipt_pkg::B_CHECK) && !done) begin
         slot_ff <= slot_ff + 1'b1;
         cnt_ff  <= cnt_ff + 1'b1;
      end
      if (rsp_load) begin
         if (op_ff == hipt_pkg::OP_LOOKUP) begin
            hit_ff   <= rd_match;
            index_ff <= rd_match ? rd_index : '0;
            kind_ff  <= hipt_pkg::KIND_FILL;
         end else begin
            hit_ff   <= 1'b0;
            index_ff <= '0;
            kind_ff  <= kind;
         end
      end
   end

   hipt_ram #(
      .WIDTH (RW),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign rsp_strobe      = strobe_ff;
   assign rsp_hit         = hit_ff;
   assign rsp_index_out   = index_ff;
   assign rsp_insert_kind = kind_ff;

endmodule

`default_nettype wire

// ===== rtl/core/hashed_index_probe_table_core.sv =====
// top level of the hashed index probe table: front, queue and back
// an accepted start passes the hashing front, the queue and up to PROBE_LIMIT probes
// in the back before rsp_strobe; the front takes no new transaction until it has
// pushed the last, and the back makes one probe per cycle through the table ram
// after reset busy stays high while the table is cleared
// results are strobed for one cycle and cannot be held off
`default_nettype none

module hashed_index_probe_table_core #(
   parameter int TABLE_DEPTH = 1024,
   parameter int PROBE_LIMIT = 4,
   parameter int INDEX_WIDTH = 24
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic                           req_operation,
   input  wire logic [hipt_pkg::KEY_WIDTH-1:0] req_key,
   input  wire logic [INDEX_WIDTH-1:0]         req_index_in,
   output logic                                rsp_strobe,
   output logic                                rsp_hit,
   output logic      [INDEX_WIDTH-1:0]         rsp_index_out,
   output logic      [1:0]                     rsp_insert_kind
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int KW = hipt_pkg::KEY_WIDTH;
   localparam int EW = 1 + KW + INDEX_WIDTH + AW;

   hipt_pkg::queue_status_type queue_status;

   logic                   clearing;
   logic                   push;
   logic                   push_operation;
   logic [KW-1:0]          push_key;
   logic [INDEX_WIDTH-1:0] push_index;
   logic [AW-1:0]          push_home;
   logic [EW-1:0]          push_data;
   logic [EW-1:0]          head_data;
   logic                   pop;

   hipt_front #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .INDEX_WIDTH (INDEX_WIDTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .hold           (clearing),
      .req_operation  (req_operation),
      .req_key        (req_key),
      .req_index_in   (req_index_in),
      .queue_full     (queue_status.full),
      .busy           (busy),
      .push           (push),
      .push_operation (push_operation),
      .push_key       (push_key),
      .push_index     (push_index),
      .push_home      (push_home)
   );

   assign push_data = {push_operation, push_key, push_index, push_home};

   hipt_queue #(
      .WIDTH (EW),
      .DEPTH (hipt_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head_data (head_data),
      .status    (queue_status)
   );

   hipt_back #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .PROBE_LIMIT (PROBE_LIMIT),
      .INDEX_WIDTH (INDEX_WIDTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_status    (queue_status),
      .head_data       (head_data),
      .pop             (pop),
      .clearing        (clearing),
      .rsp_strobe      (rsp_strobe),
      .rsp_hit         (rsp_hit),
      .rsp_index_out   (rsp_index_out),
      .rsp_insert_kind (rsp_insert_kind)
   );

endmodule

`default_nettype wire

// ===== tb/hashed_index_probe_table_core_checker.sv =====
// checker for the hashed index probe table: predicts every transaction and compares results
`timescale 1ns / 100ps

module hashed_index_probe_table_core_checker #(
   parameter int TABLE_DEPTH = 1024,
   parameter int PROBE_LIMIT = 4,
   parameter int INDEX_WIDTH = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           busy,
   input  logic                           req_operation,
   input  logic [hipt_pkg::KEY_WIDTH-1:0] req_key,
   input  logic [INDEX_WIDTH-1:0]         req_index_in,
   input  logic                           rsp_strobe,
   input  logic                           rsp_hit,
   input  logic [INDEX_WIDTH-1:0]         rsp_index_out,
   input  logic [1:0]                     rsp_insert_kind,
   output int                             fail_count,
   output int                             outstanding,
   output int                             lookup_count,
   output int                             hit_count,
   output int                             insert_count,
   output int                             update_count,
   output int                             evict_count
);

   import hipt_pkg::*;

   typedef struct packed {
      logic                   hit;
      logic [INDEX_WIDTH-1:0] index_out;
      logic [1:0]             insert_kind;
   } probe_result_type;

   logic                   table_live  [TABLE_DEPTH];
   logic [KEY_WIDTH-1:0]   table_key   [TABLE_DEPTH];
   logic [INDEX_WIDTH-1:0] table_index [TABLE_DEPTH];
   probe_result_type       pending_results[$];

   // murmur finaliser folded down to a slot address
   function automatic int unsigned hash_home(input logic [KEY_WIDTH-1:0] k);
      logic [KEY_WIDTH-1:0] h;
      h = k ^ (k >> MIX_SHIFT);
      h = h * MIX_C1;
      h = h ^ (h >> MIX_SHIFT);
      h = h * MIX_C2;
      h = h ^ (h >> MIX_SHIFT);
      return h[31:0] & (TABLE_DEPTH - 1);
   endfunction

   function automatic probe_result_type apply_request(input logic op,
                                                      input logic [KEY_WIDTH-1:0] k,
                                                      input logic [INDEX_WIDTH-1:0] ix);
      probe_result_type res;
      int unsigned      home;
      int unsigned      s;
      int unsigned      target;
      logic             done;
      int               i;
      res = '0;
      home = hash_home(k);
      target = home;
      done = 1'b0;
      if (op == OP_LOOKUP) begin
         for (i = 0; i < PROBE_LIMIT; i++) begin
            s = (home + i) & (TABLE_DEPTH - 1);
            if (!done) begin
               // an empty slot ends the probe with a miss
               if (!table_live[s]) begin
                  done = 1'b1;
               end else if (table_key[s] == k) begin
                  done = 1'b1;
                  res.hit = 1'b1;
                  res.index_out = table_index[s];
               end
            end
         end
      end else begin
         res.insert_kind = KIND_EVICT;
         for (i = 0; i < PROBE_LIMIT; i++) begin
            s = (home + i) & (TABLE_DEPTH - 1);
            if (!done && (!table_live[s] || table_key[s] == k)) begin
               res.insert_kind = table_live[s] ? KIND_UPDATE : KIND_FILL;
               target = s;
               done = 1'b1;
            end
         end
         table_live[target] = 1'b1;
         table_key[target] = k;
         table_index[target] = ix;
      end
      return res;
   endfunction

   always @(posedge clock) begin
      probe_result_type want;
      int               s;
      if (reset) begin
         for (s = 0; s < TABLE_DEPTH; s++) begin
            table_live[s] = 1'b0;
         end
         pending_results.delete();
      end else begin
         if (rsp_strobe) begin
            if (pending_results.size() == 0) begin
               $error("result strobed with no transaction outstanding");
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_hit !== want.hit) begin
                  $error("hit: expected %0d, got %0d", want.hit, rsp_hit);
                  fail_count++;
               end
               if (rsp_index_out !== want.index_out) begin
                  $error("index_out: expected 0x%0h, got 0x%0h", want.index_out, rsp_index_out);
                  fail_count++;
               end
               if (rsp_insert_kind !== want.insert_kind) begin
                  $error("insert_kind: expected %0d, got %0d", want.insert_kind,
                         rsp_insert_kind);
                  fail_count++;
               end
            end
         end
         if (start && !busy) begin
            want = apply_request(req_operation, req_key, req_index_in);
            pending_results.push_back(want);
            if (req_operation == OP_LOOKUP) begin
               lookup_count++;
               if (want.hit) hit_count++;
            end else begin
               insert_count++;
               if (want.insert_kind == KIND_UPDATE) update_count++;
               if (want.insert_kind == KIND_EVICT) evict_count++;
            end
         end
      end
      outstanding = pending_results.size();
   end

endmodule

// ===== tb/hashed_index_probe_table_core_tb.sv =====
// top of the hashed index probe table testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module hashed_index_probe_table_core_tb;

   import hipt_pkg::*;

   localparam int TABLE_DEPTH  = 1024;
   localparam int PROBE_LIMIT  = 4;
   localparam int INDEX_WIDTH  = 24;
   localparam int RANDOM_ITEMS = 1400;
   localparam int FAMILIES     = 12;
   localparam int FAMILY_SIZE  = 8;
   localparam int CYCLE_LIMIT  = 200000;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic                   req_operation;
   logic [KEY_WIDTH-1:0]   req_key;
   logic [INDEX_WIDTH-1:0] req_index_in;
   logic                   rsp_strobe;
   logic                   rsp_hit;
   logic [INDEX_WIDTH-1:0] rsp_index_out;
   logic [1:0]             rsp_insert_kind;

   int fail_count;
   int outstanding;
   int lookup_count;
   int hit_count;
   int insert_count;
   int update_count;
   int evict_count;
   int cycle_count;
   int sender_gap_pct;

   // keys that share one home slot, and clusters of keys homed close together
   logic [KEY_WIDTH-1:0] corner_keys [6];
   logic [KEY_WIDTH-1:0] family_keys [FAMILIES*FAMILY_SIZE];
   logic [KEY_WIDTH-1:0] recent_keys[$];

   hashed_index_probe_table_core #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .PROBE_LIMIT (PROBE_LIMIT),
      .INDEX_WIDTH (INDEX_WIDTH)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_operation   (req_operation),
      .req_key         (req_key),
      .req_index_in    (req_index_in),
      .rsp_strobe      (rsp_strobe),
      .rsp_hit         (rsp_hit),
      .rsp_index_out   (rsp_index_out),
      .rsp_insert_kind (rsp_insert_kind)
   );

   hashed_index_probe_table_core_checker #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .PROBE_LIMIT (PROBE_LIMIT),
      .INDEX_WIDTH (INDEX_WIDTH)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_operation   (req_operation),
      .req_key         (req_key),
      .req_index_in    (req_index_in),
      .rsp_strobe      (rsp_strobe),
      .rsp_hit         (rsp_hit),
      .rsp_index_out   (rsp_index_out),
      .rsp_insert_kind (rsp_insert_kind),
      .fail_count      (fail_count),
      .outstanding     (outstanding),
      .lookup_count    (lookup_count),
      .hit_count       (hit_count),
      .insert_count    (insert_count),
      .update_count    (update_count),
      .evict_count     (evict_count)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d transactions outstanding",
                  cycle_count, outstanding);
         $display("Some tests failed");
         $finish;
      end
   end

   // home slot of a key, used only to steer keys into collisions
   function automatic int unsigned slot_of(input logic [KEY_WIDTH-1:0] k);
      logic [KEY_WIDTH-1:0] h;
      h = k ^ (k >> MIX_SHIFT);
      h = h * MIX_C1;
      h = h ^ (h >> MIX_SHIFT);
      h = h * MIX_C2;
      h = h ^ (h >> MIX_SHIFT);
      return h[31:0] & (TABLE_DEPTH - 1);
   endfunction

   // random key whose home lies in the window of spread slots from target
   function automatic logic [KEY_WIDTH-1:0] key_near_slot(input int unsigned target,
                                                          input int unsigned spread);
      logic [KEY_WIDTH-1:0] k;
      k = {$urandom, $urandom};
      while (((slot_of(k) - target) & (TABLE_DEPTH - 1)) >= spread) begin
         k = k + 1;
      end
      return k;
   endfunction

   // entered just after a rising edge, returns at the edge that takes the transaction
   task automatic issue_request(input logic op, input logic [KEY_WIDTH-1:0] k,
                                input logic [INDEX_WIDTH-1:0] ix);
      @(negedge clock);
      while ($urandom_range(99) < sender_gap_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_operation <= op;
      req_key <= k;
      req_index_in <= ix;
      do @(posedge clock); while (busy);
   endtask

   initial begin
      logic [KEY_WIDTH-1:0]   k;
      logic [INDEX_WIDTH-1:0] ix;
      logic                   op;
      logic                   fresh;
      int unsigned            pick;
      int unsigned            target;

      start = 1'b0;
      req_operation = OP_LOOKUP;
      req_key = '0;
      req_index_in = '0;
      reset = 1'b1;
      cycle_count = 0;
      sender_gap_pct = 38;

      target = $urandom_range(TABLE_DEPTH - 1);
      for (int i = 0; i < 6; i++) corner_keys[i] = key_near_slot(target, 1);
      for (int f = 0; f < FAMILIES; f++) begin
         target = $urandom_range(TABLE_DEPTH - 1);
         for (int j = 0; j < FAMILY_SIZE; j++) begin
            family_keys[f*FAMILY_SIZE+j] = key_near_slot(target, 3);
         end
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table: the probe stops at the first slot
      issue_request(OP_LOOKUP, '0, '1);
      issue_request(OP_INSERT, '0, '0);
      issue_request(OP_INSERT, '1, '1);
      issue_request(OP_LOOKUP, '0, '0);
      issue_request(OP_LOOKUP, '1, '0);
      issue_request(OP_INSERT, '1, {(INDEX_WIDTH/2){2'b01}});
      issue_request(OP_INSERT, {32{2'b10}}, {(INDEX_WIDTH/2){2'b10}});
      issue_request(OP_LOOKUP, {32{2'b10}}, '1);
      issue_request(OP_LOOKUP, {32{2'b01}}, '0);
      // five keys on one home slot: four fills, then the home slot is evicted
      for (int i = 0; i < 5; i++) begin
         issue_request(OP_INSERT, corner_keys[i], INDEX_WIDTH'(i + 1));
      end
      // evicted and never-stored keys run out of probes, stored ones are found
      issue_request(OP_LOOKUP, corner_keys[0], '0);
      issue_request(OP_LOOKUP, corner_keys[5], '0);
      issue_request(OP_LOOKUP, corner_keys[3], '0);
      issue_request(OP_LOOKUP, corner_keys[4], '0);

      for (int phase = 0; phase < 3; phase++) begin
         sender_gap_pct = (phase == 0) ? 38 : (phase == 1) ? 46 : 0;
         for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
            pick = $urandom_range(99);
            fresh = 1'b0;
            if (pick < 60) begin
               k = family_keys[$urandom_range(FAMILIES*FAMILY_SIZE-1)];
            end else if (pick < 80 && recent_keys.size() != 0) begin
               k = recent_keys[$urandom_range(recent_keys.size() - 1)];
            end else begin
               k = {$urandom, $urandom};
               fresh = 1'b1;
            end
            op = ($urandom_range(99) < 55) ? OP_INSERT : OP_LOOKUP;
            if ($urandom_range(9) == 0) begin
               ix = $urandom_range(1) ? '1 : '0;
            end else begin
               ix = INDEX_WIDTH'($urandom);
            end
            if (op == OP_INSERT && fresh) begin
               recent_keys.push_back(k);
               if (recent_keys.size() > 64) void'(recent_keys.pop_front());
            end
            issue_request(op, k, ix);
         end
      end

      @(negedge clock);
      start <= 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (24) @(posedge clock);

      $display("covered %0d lookups (%0d hits) and %0d inserts (%0d updates, %0d evictions)",
               lookup_count, hit_count, insert_count, update_count, evict_count);
      $display("in %0d cycles, sender gaps at 38%%, then 46%%, then none", cycle_count);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
